@@ hdl/cscrc_pkg.sv @@
// Shared types and constants of the configurable serial CRC block.
package cscrc_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CRC_REG_W = 8;
    localparam int unsigned REM_W   = 7;
    localparam int unsigned RW_W    = 3;
    localparam int unsigned COUNT_W = 6;

    // Register indexes on the configuration port (paddr[3:2]).
    localparam logic [1:0] REG_POLY  = 2'd0;
    localparam logic [1:0] REG_START = 2'd1;
    localparam logic [1:0] REG_RWID  = 2'd2;
    localparam logic [1:0] REG_MBITS = 2'd3;

    // Configuration seen by every cell.
    typedef struct packed {
        logic [CRC_REG_W-1:0] poly;
        logic [RW_W-1:0]      width;   // already forced into 1..7
    } t_cell_cfg;

    // Work carried from one cell to the next.
    typedef struct packed {
        logic [CRC_REG_W-1:0] crc;
        logic [WORD_W-1:0]    word;
        logic [COUNT_W-1:0]   count;
    } t_cell_data;

endpackage

@@ hdl/cscrc_cell.sv @@
// One CRC cell: one bit position of the message, one shift/xor step, one register.
module cscrc_cell #(
    parameter int POS = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cscrc_pkg::t_cell_cfg  i_cfg,
    input  logic                  i_valid,
    input  cscrc_pkg::t_cell_data i_data,
    output logic                  o_valid,
    output cscrc_pkg::t_cell_data o_data
);

    localparam int          BIT_SEL = (POS < 32) ? POS : 0;
    localparam logic [5:0]  POS_V   = 6'(POS);

    logic                  r_valid;
    cscrc_pkg::t_cell_data r_data;
    cscrc_pkg::t_cell_data n_data;
    logic                  data_bit;
    logic                  active;
    logic [7:0]            shifted;

    always_comb begin
        data_bit = (POS < 32) ? i_data.word[BIT_SEL] : 1'b0;
        active   = POS_V < i_data.count;
        shifted  = {i_data.crc[6:0], data_bit};
        n_data   = i_data;
        if (active) begin
            n_data.crc = shifted[i_cfg.width] ? (shifted ^ i_cfg.poly) : shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/configurable_serial_crc.sv @@
// Top level of the configurable serial CRC: config registers, cell chain, output register.
//
//  port group   dir  item contents
//  -----------  ---  -------------------------------------------------------
//  s_axis_*     in   message_word (tdata[31:0])
//  m_axis_*     out  remainder (tdata[6:0], tdata[7] zero)
//  APB          cfg  poly_value @0x0, start_value @0x4, remainder_bits @0x8,
//                    message_bits @0xC
//
// One item enters per cycle while the row can advance. Each item walks a row of
// MAX_MESSAGE_BITS cells, one message bit per cell, then the output register.
// Reset is synchronous and clears the valid bits and the configuration to its
// defaults. A stalled output holds the whole row; a new item is still taken
// while the row has a free slot at its end.
module configurable_serial_crc #(
    parameter int MAX_MESSAGE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] remainder, [7] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int         NCELL = MAX_MESSAGE_BITS;
    localparam logic [6:0] MAX_V = 7'(MAX_MESSAGE_BITS);

    // Configuration registers
    logic [7:0] r_poly;
    logic [7:0] r_start;
    logic [2:0] r_rwid;
    logic [5:0] r_mbits;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= 8'd5;
            r_start <= 8'd0;
            r_rwid  <= 3'd5;
            r_mbits <= 6'd24;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                cscrc_pkg::REG_POLY:  r_poly  <= pwdata[7:0];
                cscrc_pkg::REG_START: r_start <= pwdata[7:0];
                cscrc_pkg::REG_RWID:  r_rwid  <= pwdata[2:0];
                cscrc_pkg::REG_MBITS: r_mbits <= pwdata[5:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            cscrc_pkg::REG_POLY:  prdata = {24'd0, r_poly};
            cscrc_pkg::REG_START: prdata = {24'd0, r_start};
            cscrc_pkg::REG_RWID:  prdata = {29'd0, r_rwid};
            cscrc_pkg::REG_MBITS: prdata = {26'd0, r_mbits};
        endcase
    end

    // Derived settings: zero width counts as one, bit count saturates.
    cscrc_pkg::t_cell_cfg cell_cfg;
    logic [5:0]           count_used;
    logic [6:0]           rem_mask;

    assign cell_cfg.poly  = r_poly;
    assign cell_cfg.width = (r_rwid == 3'd0) ? 3'd1 : r_rwid;
    assign count_used     = ({1'b0, r_mbits} > MAX_V) ? MAX_V[5:0] : r_mbits;
    assign rem_mask       = 7'((8'd1 << cell_cfg.width) - 8'd1);

    // Cell row: cell g handles bit position NCELL-1-g, most significant first.
    logic                  cell_valid [NCELL+1];
    cscrc_pkg::t_cell_data cell_data  [NCELL+1];
    logic                  chain_en;
    logic                  r_out_valid;
    logic [6:0]            r_out_rem;

    assign chain_en       = !cell_valid[NCELL] || !r_out_valid || m_axis_tready;
    assign s_axis_tready  = chain_en;

    assign cell_valid[0]      = s_axis_tvalid;
    assign cell_data[0].crc   = r_start;
    assign cell_data[0].word  = s_axis_tdata;
    assign cell_data[0].count = count_used;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cscrc_cell #(
            .POS(NCELL - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_cfg   (cell_cfg),
            .i_valid (cell_valid[g]),
            .i_data  (cell_data[g]),
            .o_valid (cell_valid[g+1]),
            .o_data  (cell_data[g+1])
        );
    end

    // Output register: load the finished item, drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (chain_en && cell_valid[NCELL]) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_en && cell_valid[NCELL]) begin
            r_out_rem <= cell_data[NCELL].crc[6:0] & rem_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_rem};

endmodule
